>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pool allocator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define FSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define FSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Sizes, field layout and codes shared by the pool allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package fsa_pkg;

  // Region geometry. ARENA_BYTES and MAX_SLOTS_PER_ARENA are powers of two.
  localparam int unsigned MAX_ARENAS          = 16;
  localparam int unsigned ARENA_BYTES         = 4096;
  localparam int unsigned MAX_SLOTS_PER_ARENA = 512;
  localparam int unsigned PTR_BYTES           = 8;

  // Field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = 14;
  localparam int unsigned OSIZE_W  = 13;
  localparam int unsigned OPA_W    = 10;
  localparam int unsigned BUMP_W   = 12;

  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;

  // Derived widths.
  localparam int unsigned LINK_DEPTH = MAX_ARENAS * MAX_SLOTS_PER_ARENA;
  localparam int unsigned LINK_W     = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
  localparam int unsigned AOFF_W     = $clog2(ARENA_BYTES);
  localparam int unsigned AFLD_W     = ADDR_W - AOFF_W;
  localparam int unsigned ARENA_W    = (MAX_ARENAS > 1) ? $clog2(MAX_ARENAS) : 1;
  localparam int unsigned AU_W       = $clog2(MAX_ARENAS + 1);
  localparam int unsigned SIZE_W     = $clog2(ARENA_BYTES + 1);
  localparam int unsigned QW         = $clog2(ARENA_BYTES / PTR_BYTES + 1);
  localparam int unsigned STEP_W     = (QW > 1) ? $clog2(QW) : 1;
  localparam int unsigned SW         = $clog2(MAX_SLOTS_PER_ARENA + 1);
  localparam int unsigned TRIAL_W    = SIZE_W + QW;
  localparam int unsigned PROD_W     = BUMP_W + SIZE_W;

  // Reset configuration and the slot count that follows from it.
  localparam int unsigned RST_OSIZE = 8;
  localparam int unsigned RST_OPA   = 512;
  localparam int unsigned RST_CAP   = (RST_OPA > MAX_SLOTS_PER_ARENA) ?
                                      MAX_SLOTS_PER_ARENA : RST_OPA;
  localparam int unsigned RST_FIT   = ARENA_BYTES / RST_OSIZE;
  localparam int unsigned RST_SLOTS = (RST_CAP > RST_FIT) ? RST_FIT : RST_CAP;

  // Stream word layout.
  localparam int unsigned IN_TDATA_W  = ((OP_W + ADDR_W + 7) / 8) * 8;
  localparam int unsigned O_SLOT_LSB  = 0;
  localparam int unsigned O_STS_LSB   = ADDR_W;
  localparam int unsigned O_OWN_BIT   = ADDR_W + STATUS_W;
  localparam int unsigned O_FREE_LSB  = O_OWN_BIT + 1;
  localparam int unsigned O_TOTAL_LSB = O_FREE_LSB + CNT_W;
  localparam int unsigned OUT_BITS    = O_TOTAL_LSB + CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = OSIZE_W;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECTS_PER_ARENA = 1'b1;

  // Opcodes and status codes.
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_OOM       = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_OWNED = 2'd2;

endpackage

`default_nettype wire

>>> rtl/fixed_size_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_size_pool_allocator_unit
// Fixed-size slot allocator over a region of arenas, with a free list kept in
// a link memory.
// ----------------------------------------------------------------------------
// The unit takes one request word at a time (allocate, free or ownership
// query) and returns one response word per request. Allocate pops the free
// list head, else bumps through the newest arena, else opens the next arena;
// it answers out of memory once every arena is open and full. Free checks
// ownership and pushes the slot; a free of an address that is not owned is
// reported and leaves the state unchanged. A successful allocate goes through
// ST_GROW and ST_PICK, then ST_POP for the link memory read when it pops the
// list, then ST_MUL for the slot-size multiply and ST_SUM before ST_RESP. A
// free or a query divides the offset by the slot size in a restoring divider
// that retires one quotient bit per cycle. After a configuration write the
// same divider recomputes the slots per arena before the next request word
// is taken. The result sits in an output register, so a new request is
// accepted while the previous response word still waits to be taken.
`default_nettype none

module fixed_size_pool_allocator_unit
  import fsa_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  // Request: [1:0] opcode, [17:2] address, upper bits zero.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

  // Response: [15:0] slot_address, [17:16] status, [18] is_owned,
  // [32:19] free_count, [46:33] total_count, upper bits zero.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,

  // Configuration write channel.
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;  // wait for a request or config
  localparam logic [3:0] ST_CDIV = 4'd1;  // divide arena bytes by slot size
  localparam logic [3:0] ST_CFIN = 4'd2;  // settle the slots-per-arena count
  localparam logic [3:0] ST_GROW = 4'd3;  // open a new arena if needed
  localparam logic [3:0] ST_PICK = 4'd4;  // choose list pop, bump or failure
  localparam logic [3:0] ST_POP  = 4'd5;  // link read returns the next head
  localparam logic [3:0] ST_MUL  = 4'd6;  // slot number times slot size
  localparam logic [3:0] ST_SUM  = 4'd7;  // add the arena base
  localparam logic [3:0] ST_ODIV = 4'd8;  // divide offset by slot size
  localparam logic [3:0] ST_OWN  = 4'd9;  // ownership decision, free push
  localparam logic [3:0] ST_RESP = 4'd10; // load the output register

  logic [3:0] state_q, state_d;

  // Configuration and its derived slot count.
  logic [OSIZE_W-1:0] object_size_q, object_size_d;
  logic [OPA_W-1:0]   opa_q, opa_d;
  logic               dirty_q, dirty_d;
  logic [SW-1:0]      eff_slots_q, eff_slots_d;

  // Allocator state.
  logic [LINK_W-1:0]  list_head_q, list_head_d;
  logic               list_valid_q, list_valid_d;
  logic [BUMP_W-1:0]  bump_offset_q, bump_offset_d;
  logic               bump_valid_q, bump_valid_d;
  logic [AU_W-1:0]    arenas_used_q, arenas_used_d;
  logic [CNT_W-1:0]   free_q, free_d;
  logic [CNT_W-1:0]   total_q, total_d;

  // Request being worked on.
  logic [OP_W-1:0]    op_q, op_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;

  // Divider.
  logic [SIZE_W-1:0]  rem_q, rem_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;

  // Slot address datapath.
  logic [ARENA_W-1:0] mul_arena_q, mul_arena_d;
  logic [BUMP_W-1:0]  mul_local_q, mul_local_d;
  logic [PROD_W-1:0]  prod_q, prod_d;

  // Response under construction and the output register.
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                res_own_q, res_own_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Link memory port.
  logic               ram_we;
  logic [LINK_W-1:0]  ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [LINK_W-1:0]  ram_raddr;
  logic [LINK_W-1:0]  ram_rdata;

  // Combinational helpers.
  logic [SIZE_W-1:0]  eff_size;
  logic [TRIAL_W-1:0] trial;
  logic               trial_ge;
  logic [OPA_W-1:0]   opa_nz;
  logic [SW-1:0]      slot_cap;
  logic [AFLD_W-1:0]  addr_arena;
  logic               owned;
  logic [LINK_W-1:0]  own_idx;
  logic [CNT_W:0]     free_grow;
  logic [CNT_W:0]     total_grow;
  logic [BUMP_W:0]    bump_inc;
  logic [PROD_W-1:0]  arena_base;
  logic               s_fire;
  logic               cfg_fire;

  // Slot size as used: at least a pointer, at most one arena.
  always_comb begin
    if (object_size_q < OSIZE_W'(PTR_BYTES)) begin
      eff_size = SIZE_W'(PTR_BYTES);
    end else if (object_size_q > OSIZE_W'(ARENA_BYTES)) begin
      eff_size = SIZE_W'(ARENA_BYTES);
    end else begin
      eff_size = SIZE_W'(object_size_q);
    end
  end

  // One restoring step: compare the remainder with the size shifted into
  // the current quotient bit position.
  assign trial    = TRIAL_W'(eff_size) << step_q;
  assign trial_ge = TRIAL_W'(rem_q) >= trial;

  // Slots per arena before the fit limit from the divider is applied.
  assign opa_nz   = (opa_q == '0) ? OPA_W'(1) : opa_q;
  assign slot_cap = (opa_nz > OPA_W'(MAX_SLOTS_PER_ARENA)) ?
                    SW'(MAX_SLOTS_PER_ARENA) : SW'(opa_nz);

  // Ownership: arena open, offset a whole multiple of the slot size and
  // within the slot area (quotient below the slot count).
  assign addr_arena = addr_q[ADDR_W-1:AOFF_W];
  assign owned      = (AU_W'(addr_arena) < arenas_used_q) && (rem_q == '0) &&
                      (quo_q < QW'(eff_slots_q));
  assign own_idx    = LINK_W'(LINK_W'(addr_arena) * LINK_W'(MAX_SLOTS_PER_ARENA))
                      + LINK_W'(quo_q);

  assign free_grow  = {1'b0, free_q} + (CNT_W + 1)'(eff_slots_q);
  assign total_grow = {1'b0, total_q} + (CNT_W + 1)'(eff_slots_q);
  assign bump_inc   = {1'b0, bump_offset_q} + (BUMP_W + 1)'(1);
  assign arena_base = PROD_W'(mul_arena_q) << AOFF_W;

  // A config write in the same cycle holds off a request word, so every
  // request sees a settled configuration.
  assign s_axis_tready = (state_q == ST_IDLE) && !dirty_q && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d       = state_q;
    object_size_d = object_size_q;
    opa_d         = opa_q;
    dirty_d       = dirty_q;
    eff_slots_d   = eff_slots_q;
    list_head_d   = list_head_q;
    list_valid_d  = list_valid_q;
    bump_offset_d = bump_offset_q;
    bump_valid_d  = bump_valid_q;
    arenas_used_d = arenas_used_q;
    free_d        = free_q;
    total_d       = total_q;
    op_d          = op_q;
    addr_d        = addr_q;
    rem_d         = rem_q;
    quo_d         = quo_q;
    step_d        = step_q;
    mul_arena_d   = mul_arena_q;
    mul_local_d   = mul_local_q;
    prod_d        = prod_q;
    res_addr_d    = res_addr_q;
    res_status_d  = res_status_q;
    res_own_d     = res_own_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    ram_we        = 1'b0;
    ram_waddr     = list_head_q;
    ram_wdata     = list_head_q;
    ram_re        = 1'b0;
    ram_raddr     = list_head_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          case (cfg_index_i)
            REG_OBJECT_SIZE:       object_size_d = cfg_data_i[OSIZE_W-1:0];
            REG_OBJECTS_PER_ARENA: opa_d         = cfg_data_i[OPA_W-1:0];
            default: ;
          endcase
          dirty_d = 1'b1;
        end else if (dirty_q) begin
          // Fit of slots into one arena: ARENA_BYTES / slot size.
          rem_d   = SIZE_W'(ARENA_BYTES);
          quo_d   = '0;
          step_d  = STEP_W'(QW - 1);
          dirty_d = 1'b0;
          state_d = ST_CDIV;
        end else if (s_fire) begin
          op_d         = s_axis_tdata[OP_W-1:0];
          addr_d       = s_axis_tdata[OP_W +: ADDR_W];
          res_addr_d   = '0;
          res_status_d = STS_OK;
          res_own_d    = 1'b0;
          if (s_axis_tdata[OP_W-1:0] == OP_ALLOC) begin
            state_d = ST_GROW;
          end else begin
            rem_d   = SIZE_W'(s_axis_tdata[OP_W +: AOFF_W]);
            quo_d   = '0;
            step_d  = STEP_W'(QW - 1);
            state_d = ST_ODIV;
          end
        end
      end

      ST_CDIV, ST_ODIV: begin
        if (trial_ge) begin
          rem_d = SIZE_W'(TRIAL_W'(rem_q) - trial);
        end
        quo_d  = {quo_q[QW-2:0], trial_ge};
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = (state_q == ST_CDIV) ? ST_CFIN : ST_OWN;
        end
      end

      ST_CFIN: begin
        eff_slots_d = (QW'(slot_cap) > quo_q) ? SW'(quo_q) : slot_cap;
        state_d     = ST_IDLE;
      end

      ST_GROW: begin
        if (!list_valid_q && !bump_valid_q &&
            (arenas_used_q < AU_W'(MAX_ARENAS))) begin
          arenas_used_d = arenas_used_q + AU_W'(1);
          bump_offset_d = '0;
          bump_valid_d  = 1'b1;
          free_d  = (free_grow > (CNT_W + 1)'(CNT_MAX)) ?
                    CNT_W'(CNT_MAX) : free_grow[CNT_W-1:0];
          total_d = (total_grow > (CNT_W + 1)'(CNT_MAX)) ?
                    CNT_W'(CNT_MAX) : total_grow[CNT_W-1:0];
        end
        state_d = ST_PICK;
      end

      ST_PICK: begin
        if (list_valid_q) begin
          ram_re      = 1'b1;
          ram_raddr   = list_head_q;
          mul_arena_d = ARENA_W'(list_head_q / MAX_SLOTS_PER_ARENA);
          mul_local_d = BUMP_W'(list_head_q % MAX_SLOTS_PER_ARENA);
          if (free_q != '0) begin
            free_d = free_q - CNT_W'(1);
          end
          state_d = ST_POP;
        end else if (bump_valid_q) begin
          mul_arena_d   = ARENA_W'(arenas_used_q - AU_W'(1));
          mul_local_d   = bump_offset_q;
          bump_offset_d = bump_inc[BUMP_W-1:0];
          if (bump_inc >= (BUMP_W + 1)'(eff_slots_q)) begin
            bump_valid_d = 1'b0;
          end
          if (free_q != '0) begin
            free_d = free_q - CNT_W'(1);
          end
          state_d = ST_MUL;
        end else begin
          res_status_d = STS_OOM;
          state_d      = ST_RESP;
        end
      end

      ST_POP: begin
        // The last list element links to itself.
        if (ram_rdata == list_head_q) begin
          list_valid_d = 1'b0;
        end else begin
          list_head_d = ram_rdata;
        end
        state_d = ST_MUL;
      end

      ST_MUL: begin
        prod_d  = PROD_W'(mul_local_q) * PROD_W'(eff_size);
        state_d = ST_SUM;
      end

      ST_SUM: begin
        res_addr_d = ADDR_W'(arena_base + prod_q);
        state_d    = ST_RESP;
      end

      ST_OWN: begin
        if (op_q == OP_FREE) begin
          if (owned) begin
            ram_we       = 1'b1;
            ram_waddr    = own_idx;
            ram_wdata    = list_valid_q ? list_head_q : own_idx;
            list_head_d  = own_idx;
            list_valid_d = 1'b1;
            res_own_d    = 1'b1;
            if (free_q != CNT_W'(CNT_MAX)) begin
              free_d = free_q + CNT_W'(1);
            end
          end else begin
            res_status_d = STS_NOT_OWNED;
          end
        end else begin
          res_own_d = owned;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[O_SLOT_LSB +: ADDR_W]  = res_addr_q;
          out_data_d[O_STS_LSB +: STATUS_W] = res_status_q;
          out_data_d[O_OWN_BIT]             = res_own_q;
          out_data_d[O_FREE_LSB +: CNT_W]   = free_q;
          out_data_d[O_TOTAL_LSB +: CNT_W]  = total_q;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      object_size_q <= OSIZE_W'(RST_OSIZE);
      opa_q         <= OPA_W'(RST_OPA);
      dirty_q       <= 1'b0;
      eff_slots_q   <= SW'(RST_SLOTS);
      list_head_q   <= '0;
      list_valid_q  <= 1'b0;
      bump_offset_q <= '0;
      bump_valid_q  <= 1'b0;
      arenas_used_q <= '0;
      free_q        <= '0;
      total_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      object_size_q <= object_size_d;
      opa_q         <= opa_d;
      dirty_q       <= dirty_d;
      eff_slots_q   <= eff_slots_d;
      list_head_q   <= list_head_d;
      list_valid_q  <= list_valid_d;
      bump_offset_q <= bump_offset_d;
      bump_valid_q  <= bump_valid_d;
      arenas_used_q <= arenas_used_d;
      free_q        <= free_d;
      total_q       <= total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    step_q       <= step_d;
    mul_arena_q  <= mul_arena_d;
    mul_local_q  <= mul_local_d;
    prod_q       <= prod_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
    res_own_q    <= res_own_d;
    out_data_q   <= out_data_d;
  end

  // Link memory. Writes happen only in ST_OWN and reads only in ST_PICK of
  // a later request, so a read never overlaps a write to the same entry.
  fsa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

>>> rtl/fsa_ram.sv
// ----------------------------------------------------------------------------
// fsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/fsa_checker.sv
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks on the pool allocator response stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fsa_checker
  import fsa_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [ADDR_W-1:0]   slot_addr;
  logic [STATUS_W-1:0] sts;
  logic                own;

  assign slot_addr = m_axis_tdata[O_SLOT_LSB +: ADDR_W];
  assign sts       = m_axis_tdata[O_STS_LSB +: STATUS_W];
  assign own       = m_axis_tdata[O_OWN_BIT];

  `FSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "response word dropped while stalled")
  `FSA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "response word changed while stalled")
  `FSA_ASSERT_IMPL(a_fail_no_addr, clk_i, rst_ni, m_axis_tvalid && (sts != STS_OK), slot_addr == '0, "failed request carries a slot address")
  `FSA_ASSERT_IMPL(a_not_owned_flag, clk_i, rst_ni, m_axis_tvalid && (sts == STS_NOT_OWNED), !own, "not-owned free reports ownership")
  `FSA_ASSERT_IMPL(a_owned_ok, clk_i, rst_ni, m_axis_tvalid && own, sts == STS_OK, "owned address with an error status")

endmodule

bind fixed_size_pool_allocator_unit fsa_checker u_fsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
